// ----- rtl/core/dsts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_pkg
// Shared types, constants and the byte weight ROM of the subdomain scorer.
// ----------------------------------------------------------------------------
package dsts_pkg;

  // Name length limit and weight format.
  localparam int MAX_NAME_BYTES   = 1023;
  localparam int WEIGHT_FRAC_BITS = 12;

  // Field widths of the beats.
  localparam int BYTE_W  = 8;
  localparam int SCORE_W = 26;
  localparam int CNT_W   = 10;
  localparam int BAND_W  = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  // Running counters must hold the length limit itself.
  localparam int LEN_W  = $clog2(MAX_NAME_BYTES + 1);
  localparam int CNTX_W = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  // Weight scaling from the Q.12 ROM to the working format.
  localparam int SHL      = (WEIGHT_FRAC_BITS >= 12) ? WEIGHT_FRAC_BITS - 12 : 0;
  localparam int SHR      = (WEIGHT_FRAC_BITS >= 12) ? 0 : 12 - WEIGHT_FRAC_BITS;
  localparam int RND      = (1 << SHR) >> 1;
  localparam int WEIGHT_W = 16 + SHL;

  // Band compare widths.
  localparam int PROD_W = BAND_W + LEN_W;
  localparam int CMP_W  = (PROD_W > SCORE_W) ? PROD_W : SCORE_W;

  localparam logic [SCORE_W-1:0] SUM_MAX = {SCORE_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX = {CNT_W{1'b1}};
  localparam logic [LEN_W-1:0]   LEN_LIMIT = LEN_W'(MAX_NAME_BYTES);

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_BAND_LOW    = 2'd0;
  localparam logic [IDX_W-1:0] REG_BAND_HIGH   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_SYMBOLS = 2'd2;

  // Configuration reset values.
  localparam logic [BAND_W-1:0] BAND_LOW_RST    = 16'd11469;
  localparam logic [BAND_W-1:0] BAND_HIGH_RST   = 16'd19661;
  localparam logic [CNT_W-1:0]  MIN_SYMBOLS_RST = 10'd8;

  // Character codes that steer the counters.
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_HYPHEN = 8'h2D;

  // Fixed Q.12 weights.
  localparam logic [15:0] W_ZERO  = 16'd13107;
  localparam logic [15:0] W_ONE   = 16'd9830;
  localparam logic [15:0] W_DIGIT = 16'd2048;
  localparam logic [15:0] W_OTHER = 16'd24576;

  // English letter frequencies, A through Z, Q.12.
  localparam logic [15:0] LETTER_Q12 [26] = '{
    16'd34597, 16'd6735,  16'd13089, 16'd15855, 16'd46734, 16'd8128,
    16'd7457,  16'd17429, 16'd29205, 16'd842,   16'd3668,  16'd15865,
    16'd10944, 16'd27732, 16'd28884, 16'd8288,  16'd341,   16'd25487,
    16'd28563, 16'd33524, 16'd12097, 16'd4089,  16'd6955,  16'd722,
    16'd7346,  16'd321
  };

  typedef struct packed {
    logic [BYTE_W-1:0] name_byte;
    logic              last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic               detected;
    logic [CNT_W-1:0]   subdomain_length;
    logic [CNT_W-1:0]   symbol_count;
    logic [SCORE_W-1:0] score_sum;
  } verdict_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   sym;
  } totals_t;

  // Weight of one byte in the working fixed-point format.
  function automatic logic [WEIGHT_W-1:0] byte_weight(input logic [BYTE_W-1:0] b);
    logic [15:0]       q;
    logic [4:0]        idx;
    logic [WEIGHT_W:0] tmp;
    // Upper and lower case differ by 0x20, so the low five bits minus one
    // give the letter position for both.
    idx = b[4:0] - 5'd1;
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
      q = LETTER_Q12[idx];
    end else if (b == 8'h30) begin
      q = W_ZERO;
    end else if (b == 8'h31) begin
      q = W_ONE;
    end else if (b >= 8'h32 && b <= 8'h39) begin
      q = W_DIGIT;
    end else begin
      q = W_OTHER;
    end
    tmp = (WEIGHT_W + 1)'(q) + (WEIGHT_W + 1)'(RND);
    tmp = tmp << SHL;
    return WEIGHT_W'(tmp >> SHR);
  endfunction

  // Clamp a running count to the output field width.
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [LEN_W-1:0] v);
    logic [CNTX_W-1:0] vx;
    vx = CNTX_W'(v);
    if (vx > CNTX_W'(CNT_MAX)) begin
      return CNT_MAX;
    end
    return CNT_W'(vx);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dsts_accum.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_accum
// Input register and running totals; hands out the subdomain totals at the
// final byte of each name.
// ----------------------------------------------------------------------------
module dsts_accum (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_valid,
  output logic                     byte_ready,
  input  wire dsts_pkg::byte_beat_t byte_data,
  output logic                     sub_valid,
  input  wire logic                sub_ready,
  output dsts_pkg::totals_t        sub_totals
);
  import dsts_pkg::*;

  logic         s0_valid;
  byte_beat_t   s0_beat;
  logic         s0_take;
  logic         sub_free;

  logic [SCORE_W-1:0] run_score, run_score_next;
  logic [LEN_W-1:0]   run_length, run_length_next;
  logic [LEN_W-1:0]   run_symbols, run_symbols_next;
  totals_t            snap_last_dot, snap_last_dot_next;
  totals_t            snap_prev_dot, snap_prev_dot_next;
  logic [1:0]         dots_seen, dots_seen_next;
  totals_t            sub_next;

  logic               active;
  logic               is_dot;
  logic               is_sym;
  logic [SCORE_W:0]   score_sum;

  // A final byte may only leave when the totals slot is free.
  assign sub_free   = !sub_valid || sub_ready;
  assign s0_take    = s0_valid && (!s0_beat.last_byte || sub_free);
  assign byte_ready = !s0_valid || s0_take;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (byte_ready) begin
      s0_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready) begin
      s0_beat <= byte_data;
    end
  end

  // Next totals for the byte in the input register.
  always_comb begin
    active = run_length < LEN_LIMIT;
    is_dot = s0_beat.name_byte == CH_DOT;
    is_sym = !is_dot && (s0_beat.name_byte != CH_HYPHEN);
    score_sum = (SCORE_W + 1)'(run_score) + (SCORE_W + 1)'(byte_weight(s0_beat.name_byte));

    run_score_next     = run_score;
    run_length_next    = run_length;
    run_symbols_next   = run_symbols;
    snap_last_dot_next = snap_last_dot;
    snap_prev_dot_next = snap_prev_dot;
    dots_seen_next     = dots_seen;

    if (active) begin
      if (is_dot) begin
        snap_prev_dot_next = snap_last_dot;
        snap_last_dot_next = '{score: run_score, len: run_length, sym: run_symbols};
        if (dots_seen != 2'd2) begin
          dots_seen_next = dots_seen + 2'd1;
        end
      end
      run_score_next  = score_sum[SCORE_W] ? SUM_MAX : score_sum[SCORE_W-1:0];
      run_length_next = run_length + LEN_W'(1);
      if (is_sym) begin
        run_symbols_next = run_symbols + LEN_W'(1);
      end
    end

    // The subdomain ends at the second-to-last dot; empty with fewer dots.
    sub_next = (dots_seen_next == 2'd2) ? snap_prev_dot_next : '0;
  end

  // Running state; cleared after the final byte of each name.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_score     <= '0;
      run_length    <= '0;
      run_symbols   <= '0;
      snap_last_dot <= '0;
      snap_prev_dot <= '0;
      dots_seen     <= 2'd0;
    end else if (s0_take) begin
      if (s0_beat.last_byte) begin
        run_score     <= '0;
        run_length    <= '0;
        run_symbols   <= '0;
        snap_last_dot <= '0;
        snap_prev_dot <= '0;
        dots_seen     <= 2'd0;
      end else begin
        run_score     <= run_score_next;
        run_length    <= run_length_next;
        run_symbols   <= run_symbols_next;
        snap_last_dot <= snap_last_dot_next;
        snap_prev_dot <= snap_prev_dot_next;
        dots_seen     <= dots_seen_next;
      end
    end
  end

  // Subdomain totals slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_valid <= 1'b0;
    end else if (s0_take && s0_beat.last_byte) begin
      sub_valid <= 1'b1;
    end else if (sub_ready) begin
      sub_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_take && s0_beat.last_byte) begin
      sub_totals <= sub_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/dsts_judge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dsts_judge
// Band products, threshold and band compare, and the verdict register.
// ----------------------------------------------------------------------------
module dsts_judge (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [dsts_pkg::BAND_W-1:0]  band_low,
  input  wire logic [dsts_pkg::BAND_W-1:0]  band_high,
  input  wire logic [dsts_pkg::CNT_W-1:0]   min_symbols,
  input  wire logic                         sub_valid,
  output logic                              sub_ready,
  input  wire dsts_pkg::totals_t            sub_totals,
  output logic                              verdict_valid,
  input  wire logic                         verdict_ready,
  output dsts_pkg::verdict_t                verdict_data
);
  import dsts_pkg::*;

  logic              s2_valid;
  logic              s2_move;
  logic              out_free;
  totals_t           s2_sub;
  logic [PROD_W-1:0] s2_lo;
  logic [PROD_W-1:0] s2_hi;
  logic              s2_sym_ok;
  logic              s2_len_nz;
  logic [CMP_W-1:0]  score_x;
  logic              in_band;

  assign out_free  = !verdict_valid || verdict_ready;
  assign s2_move   = s2_valid && out_free;
  assign sub_ready = !s2_valid || s2_move;

  // Product stage: the bounds times the subdomain length.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (sub_ready) begin
      s2_valid <= sub_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sub_ready) begin
      s2_sub    <= sub_totals;
      s2_lo     <= PROD_W'(band_low) * PROD_W'(sub_totals.len);
      s2_hi     <= PROD_W'(band_high) * PROD_W'(sub_totals.len);
      s2_sym_ok <= CNTX_W'(sub_totals.sym) >= CNTX_W'(min_symbols);
      s2_len_nz <= sub_totals.len != '0;
    end
  end

  // Mean test as sum against bound times length.
  assign score_x = CMP_W'(s2_sub.score);
  assign in_band = (score_x >= CMP_W'(s2_lo)) && (score_x <= CMP_W'(s2_hi));

  // Verdict register.
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s2_move) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      verdict_data.detected         <= s2_len_nz && s2_sym_ok && in_band;
      verdict_data.subdomain_length <= sat_cnt(s2_sub.len);
      verdict_data.symbol_count     <= sat_cnt(s2_sub.sym);
      verdict_data.score_sum        <= s2_sub.score;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/dns_subdomain_tunnel_scorer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dns_subdomain_tunnel_scorer
// Scores the subdomain of a domain name streamed one byte per beat and
// returns one verdict beat after the final byte of each name.
// Path: input register, totals slot, product stage, then verdict register.
// Throughput: one name byte per cycle; bytes keep flowing while a verdict
// waits, until a final byte stalls the input behind two full slots.
// Reset: synchronous rst clears the running totals and valid flags and loads
// the band and threshold registers with their defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
module dns_subdomain_tunnel_scorer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        byte_valid,
  output logic                             byte_ready,
  input  wire dsts_pkg::byte_beat_t        byte_data,
  output logic                             verdict_valid,
  input  wire logic                        verdict_ready,
  output dsts_pkg::verdict_t               verdict_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [dsts_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [dsts_pkg::CFG_W-1:0]  cfg_data
);
  import dsts_pkg::*;

  logic [BAND_W-1:0] band_low;
  logic [BAND_W-1:0] band_high;
  logic [CNT_W-1:0]  min_symbols;
  logic              sub_valid;
  logic              sub_ready;
  totals_t           sub_totals;

  // Configuration registers accept a write every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_low    <= BAND_LOW_RST;
      band_high   <= BAND_HIGH_RST;
      min_symbols <= MIN_SYMBOLS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BAND_LOW:    band_low    <= cfg_data;
        REG_BAND_HIGH:   band_high   <= cfg_data;
        REG_MIN_SYMBOLS: min_symbols <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Running totals and subdomain snapshot.
  dsts_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .sub_valid  (sub_valid),
    .sub_ready  (sub_ready),
    .sub_totals (sub_totals)
  );

  // Band test and verdict register.
  dsts_judge u_judge (
    .clk           (clk),
    .rst           (rst),
    .band_low      (band_low),
    .band_high     (band_high),
    .min_symbols   (min_symbols),
    .sub_valid     (sub_valid),
    .sub_ready     (sub_ready),
    .sub_totals    (sub_totals),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict_data  (verdict_data)
  );

endmodule
`default_nettype wire
